// ===== src/bsenc_pkg.sv =====
// Shared types, constants and functions of the Bech32 string encoder.
// No dependencies; every other file refers to it by scoped names.
package bsenc_pkg;

  // Depth of the prefix low-bit store and the matching address width
  localparam int PREFIX_DEPTH = 128;
  localparam int ADDR_W       = $clog2(PREFIX_DEPTH);
  localparam int CNT_W        = 7;

  // Final constants of the two variants
  localparam logic [29:0] BECH32_CONST  = 30'h0000_0001;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc8_30a3;

  // Register indexes of the configuration port
  localparam logic REG_VARIANT = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [6:0] MAX_LEN_RESET = 7'd90;

  // Configuration as seen by the engine
  typedef struct packed {
    logic       variant;
    logic [6:0] max_len;
  } bsenc_cfg_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       err;
    logic [2:0] code;
  } bsenc_beat_t;

  // One step of the 30-bit polymod over a zero symbol
  function automatic logic [29:0] poly_step(input logic [29:0] acc);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], 5'b0};
    if (top[0]) r = r ^ 30'h3b6a57b2;
    if (top[1]) r = r ^ 30'h26508e6d;
    if (top[2]) r = r ^ 30'h1ea119fa;
    if (top[3]) r = r ^ 30'h3d4233dd;
    if (top[4]) r = r ^ 30'h2a1462b3;
    return r;
  endfunction

  // Map a 5-bit value to its charset symbol
  function automatic logic [7:0] charset(input logic [4:0] v);
    logic [7:0] c;
    case (v)
      5'd0:  c = "q";
      5'd1:  c = "p";
      5'd2:  c = "z";
      5'd3:  c = "r";
      5'd4:  c = "y";
      5'd5:  c = "9";
      5'd6:  c = "x";
      5'd7:  c = "8";
      5'd8:  c = "g";
      5'd9:  c = "f";
      5'd10: c = "2";
      5'd11: c = "t";
      5'd12: c = "v";
      5'd13: c = "d";
      5'd14: c = "w";
      5'd15: c = "0";
      5'd16: c = "s";
      5'd17: c = "3";
      5'd18: c = "j";
      5'd19: c = "n";
      5'd20: c = "5";
      5'd21: c = "4";
      5'd22: c = "k";
      5'd23: c = "h";
      5'd24: c = "c";
      5'd25: c = "e";
      5'd26: c = "6";
      5'd27: c = "m";
      5'd28: c = "u";
      5'd29: c = "a";
      5'd30: c = "7";
      default: c = "l";
    endcase
    return c;
  endfunction

endpackage

// ===== src/bsenc_cfg_regs.sv =====
// Configuration registers of the Bech32 string encoder behind an APB-style port.
// Depends on bsenc_pkg.
module bsenc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output bsenc_pkg::bsenc_cfg_t cfg
);

  logic       variant_r;
  logic [6:0] max_len_r;
  logic       wr_en;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
      max_len_r <= bsenc_pkg::MAX_LEN_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        bsenc_pkg::REG_VARIANT: variant_r <= cfg_pwdata[0];
        bsenc_pkg::REG_MAX_LEN: max_len_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Decode read data
  always_comb begin
    unique case (cfg_paddr[2])
      bsenc_pkg::REG_VARIANT: cfg_prdata = {31'b0, variant_r};
      bsenc_pkg::REG_MAX_LEN: cfg_prdata = {25'b0, max_len_r};
      default:                cfg_prdata = 32'b0;
    endcase
  end

  assign cfg.variant = variant_r;
  assign cfg.max_len = max_len_r;

endmodule

// ===== src/bsenc_engine.sv =====
// Sequencer of the Bech32 string encoder: validation, polymod accumulator and
// the prefix low-bit memory with its replay walk. Depends on bsenc_pkg.
module bsenc_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_operation,
  input  logic [7:0]             in_item_value,
  input  bsenc_pkg::bsenc_cfg_t  cfg,
  input  logic                   out_free,
  output logic                   emit,
  output bsenc_pkg::bsenc_beat_t beat
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_CLOSE0   = 3'd2;
  localparam logic [2:0] ST_CLOSE_RD = 3'd3;
  localparam logic [2:0] ST_SEP      = 3'd4;
  localparam logic [2:0] ST_DATA     = 3'd5;
  localparam logic [2:0] ST_FIN_STEP = 3'd6;
  localparam logic [2:0] ST_FIN_EMIT = 3'd7;

  localparam logic [1:0] OP_PREFIX = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG = 3'd2;
  localparam logic [2:0] ERR_DATA_BIG = 3'd3;
  localparam logic [2:0] ERR_ORDER    = 3'd4;

  localparam int AW = bsenc_pkg::ADDR_W;
  localparam int CW = bsenc_pkg::CNT_W;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [29:0]   acc_r, acc_nxt;
  logic [CW-1:0] pc_r, pc_nxt;
  logic [CW-1:0] dc_r, dc_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]    cnt_r, cnt_nxt;

  // Prefix low-bit store
  logic [4:0]    low_mem [bsenc_pkg::PREFIX_DEPTH];
  logic [4:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic [8:0]    sum_pd;
  logic          len_pfx_bad;
  logic          pfx_full;
  logic          data_len_bad;
  logic          end_len_bad;
  logic          bad_char;
  logic [2:0]    err_code;
  logic          do_data;
  logic [29:0]   step_acc;
  logic [CW:0]   idx_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign step_acc = bsenc_pkg::poly_step(acc_r);
  assign wr_addr  = AW'(pc_r);
  assign idx_inc  = {1'b0, idx_r} + 1'b1;

  // Length and character checks against the current counts
  assign sum_pd       = 9'(pc_r) + 9'(dc_r);
  assign len_pfx_bad  = (9'(pc_r) + 9'd8) > 9'(cfg.max_len);
  assign pfx_full     = 32'(pc_r) >= 32'(bsenc_pkg::PREFIX_DEPTH);
  assign data_len_bad = (sum_pd + 9'd8) > 9'(cfg.max_len);
  assign end_len_bad  = (sum_pd + 9'd7) > 9'(cfg.max_len);
  assign bad_char     = (val_r < 8'd33) || (val_r > 8'd126) ||
                        ((val_r >= 8'd65) && (val_r <= 8'd90));

  // Pick the first error of the held item, in stream order
  always_comb begin
    err_code = ERR_NONE;
    case (op_r)
      OP_PREFIX: begin
        if (phase_r != PH_PREFIX)       err_code = ERR_ORDER;
        else if (bad_char)              err_code = ERR_BAD_CHAR;
        else if (pfx_full || len_pfx_bad) err_code = ERR_TOO_LONG;
      end
      OP_DATA: begin
        if (data_len_bad)               err_code = ERR_TOO_LONG;
        else if (val_r > 8'd31)         err_code = ERR_DATA_BIG;
      end
      OP_END: begin
        if (end_len_bad)                err_code = ERR_TOO_LONG;
      end
      default: err_code = ERR_NONE;
    endcase
  end

  // Sequence one item through validation, replay, and result beats
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    acc_nxt   = acc_r;
    pc_nxt    = pc_r;
    dc_nxt    = dc_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    rd_addr   = '0;
    emit      = 1'b0;
    do_data   = 1'b0;
    beat      = '{out_char: 8'd0, last: 1'b0, err: 1'b0, code: ERR_NONE};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          val_nxt   = in_item_value;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_NONE) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_ERROR) begin
          // Drop items until the end marker, which clears the stream
          if (op_r == OP_END) begin
            acc_nxt   = 30'd1;
            pc_nxt    = '0;
            dc_nxt    = '0;
            phase_nxt = PH_PREFIX;
          end
          state_nxt = ST_IDLE;
        end else if (err_code != ERR_NONE) begin
          if (out_free) begin
            emit      = 1'b1;
            beat      = '{out_char: 8'd0, last: 1'b1, err: 1'b1, code: err_code};
            phase_nxt = PH_ERROR;
            state_nxt = ST_IDLE;
          end
        end else begin
          case (op_r)
            OP_PREFIX: begin
              if (out_free) begin
                emit      = 1'b1;
                beat.out_char = val_r;
                acc_nxt   = step_acc ^ {27'b0, val_r[7:5]};
                mem_we    = 1'b1;
                pc_nxt    = pc_r + 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            OP_DATA: begin
              if (phase_r == PH_PREFIX) state_nxt = ST_CLOSE0;
              else                      do_data   = 1'b1;
            end
            default: begin
              cnt_nxt = '0;
              if (phase_r == PH_PREFIX) state_nxt = ST_CLOSE0;
              else                      state_nxt = ST_FIN_STEP;
            end
          endcase
        end
      end
      ST_CLOSE0: begin
        // Zero step, then start the walk over the stored low bits
        acc_nxt = step_acc;
        idx_nxt = '0;
        rd_addr = '0;
        if (pc_r == '0) state_nxt = ST_SEP;
        else            state_nxt = ST_CLOSE_RD;
      end
      ST_CLOSE_RD: begin
        acc_nxt = step_acc ^ {25'b0, mem_q};
        idx_nxt = idx_inc[CW-1:0];
        rd_addr = AW'(idx_inc);
        if (idx_inc == {1'b0, pc_r}) state_nxt = ST_SEP;
      end
      ST_SEP: begin
        if (out_free) begin
          emit          = 1'b1;
          beat.out_char = "1";
          phase_nxt     = PH_DATA;
          cnt_nxt       = '0;
          state_nxt     = (op_r == OP_DATA) ? ST_DATA : ST_FIN_STEP;
        end
      end
      ST_DATA: begin
        do_data = 1'b1;
      end
      ST_FIN_STEP: begin
        // Six zero steps, then fold in the variant constant
        acc_nxt = step_acc;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'd5) begin
          acc_nxt   = step_acc ^ (cfg.variant ? bsenc_pkg::BECH32M_CONST
                                              : bsenc_pkg::BECH32_CONST);
          cnt_nxt   = '0;
          state_nxt = ST_FIN_EMIT;
        end
      end
      ST_FIN_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          beat.out_char = bsenc_pkg::charset(acc_r[29:25]);
          beat.last     = (cnt_r == 3'd5);
          acc_nxt       = {acc_r[24:0], 5'b0};
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == 3'd5) begin
            acc_nxt   = 30'd1;
            pc_nxt    = '0;
            dc_nxt    = '0;
            phase_nxt = PH_PREFIX;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Emit one data symbol and fold its value in
    if (do_data && out_free) begin
      emit          = 1'b1;
      beat.out_char = bsenc_pkg::charset(val_r[4:0]);
      acc_nxt       = step_acc ^ {25'b0, val_r[4:0]};
      dc_nxt        = dc_r + 1'b1;
      phase_nxt     = PH_DATA;
      state_nxt     = ST_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= 30'd1;
      pc_r    <= '0;
      dc_r    <= '0;
      phase_r <= PH_PREFIX;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      pc_r    <= pc_nxt;
      dc_r    <= dc_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Held item
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    val_r <= val_nxt;
  end

  // Store writes during the prefix; reads happen only in the later walk,
  // so a write and a read of one entry never meet
  always_ff @(posedge clk) begin
    if (mem_we) begin
      low_mem[wr_addr] <= val_r[4:0];
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= low_mem[rd_addr];
  end

  // A beat goes out only into a free output register
  assert property (@(posedge clk) disable iff (!rst_n) emit |-> out_free)
    else $error("beat emitted into a full output register");

  // The store is written only while the prefix is open
  assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> (phase_r == PH_PREFIX))
    else $error("prefix store written outside the prefix phase");

  // The replay walk stays inside the written part of the store
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE_RD) |-> (idx_r < pc_r))
    else $error("replay read beyond the stored prefix");

  // An error beat leaves the stream in the error phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && beat.err) |=> (phase_r == PH_ERROR))
    else $error("error beat without error phase");

  // The last checksum beat returns the stream to its reset state
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && beat.last && !beat.err) |=>
      (pc_r == '0 && dc_r == '0 && acc_r == 30'd1 && phase_r == PH_PREFIX))
    else $error("stream state not cleared after the last checksum beat");

endmodule

// ===== src/bsenc_out_reg.sv =====
// Output register of the Bech32 string encoder: holds one beat until taken.
// Depends on bsenc_pkg.
module bsenc_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   emit,
  input  bsenc_pkg::bsenc_beat_t beat,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_char,
  output logic                   out_last_of_string,
  output logic                   out_error_flag,
  output logic [2:0]             out_error_code
);

  logic                   valid_r;
  bsenc_pkg::bsenc_beat_t beat_r;

  // Free when empty or when the held beat leaves this cycle
  assign out_free = !valid_r || !out_stall;

  // Load a new beat or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      beat_r <= beat;
    end
  end

  assign out_valid          = valid_r;
  assign out_char           = beat_r.out_char;
  assign out_last_of_string = beat_r.last;
  assign out_error_flag     = beat_r.err;
  assign out_error_code     = beat_r.code;

endmodule

// ===== src/bech32_string_encoder_core.sv =====
// Top level of the Bech32 / Bech32m string encoder.
// Depends on bsenc_pkg, bsenc_cfg_regs, bsenc_engine and bsenc_out_reg.

// The block takes one item at a time and turns it into zero to seven output
// characters, each one beat on the out_ channel, held in an output register.
// A prefix character or a data value is taken in the idle state and handled
// in the execute state. The first data value or end marker after the prefix
// walks the prefix store, one entry per cycle through its one read port, then
// emits the separator. The end marker adds six checksum steps in the shared
// polymod unit and six checksum characters. A stalled output register holds
// the sequencer at its next beat. No clearing pass is needed after reset.
// Configuration is written through the cfg_ port, variant at byte address 0
// and maximum length at byte address 4.
module bech32_string_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_of_string,
  output logic        out_error_flag,
  output logic [2:0]  out_error_code,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bsenc_pkg::bsenc_cfg_t  cfg;
  bsenc_pkg::bsenc_beat_t beat;
  logic                   emit;
  logic                   out_free;

  bsenc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bsenc_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_item_value (in_item_value),
    .cfg           (cfg),
    .out_free      (out_free),
    .emit          (emit),
    .beat          (beat)
  );

  bsenc_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .emit               (emit),
    .beat               (beat),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char           (out_char),
    .out_last_of_string (out_last_of_string),
    .out_error_flag     (out_error_flag),
    .out_error_code     (out_error_code)
  );

endmodule
